[design/hlw_pkg.sv]
package hlw_pkg;

   // Operating mode of the watched host
   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_BOOTING  = 2'd1,
      MODE_SHUTTING = 2'd2
   } mode_type;

   // Mode selector code that a set-mode command must ignore
   localparam logic [1:0] MODE_SEL_INVALID = 2'd3;

   // Item opcodes
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_POLL     = 2'd1;
   localparam logic [1:0] OP_SET_MODE = 2'd2;

   // Event codes reported with each result
   typedef enum logic [3:0] {
      EV_NONE         = 4'd0,
      EV_LEARNED      = 4'd1,
      EV_BOOTED       = 4'd2,
      EV_BOOT_TIMEOUT = 4'd3,
      EV_SHUT_DOWN    = 4'd4,
      EV_PROBE_MISS   = 4'd5,
      EV_REFRESHED    = 4'd6,
      EV_RESOLVE_MISS = 4'd7,
      EV_FREEZE       = 4'd8
   } event_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_PROBE_MISS_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_RESOLVE_MISS_LIMIT = 2'd1;
   localparam logic [1:0] CSR_BOOT_WINDOW        = 2'd2;
   localparam logic [1:0] CSR_SHUTDOWN_WINDOW    = 2'd3;

   // Configuration reset values
   localparam logic [3:0]  PROBE_MISS_LIMIT_RST   = 4'd3;
   localparam logic [3:0]  RESOLVE_MISS_LIMIT_RST = 4'd2;
   localparam logic [15:0] BOOT_WINDOW_RST        = 16'd60000;
   localparam logic [15:0] SHUTDOWN_WINDOW_RST    = 16'd30000;

   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   typedef struct packed {
      logic [3:0]  probe_miss_limit;
      logic [3:0]  resolve_miss_limit;
      logic [15:0] boot_window;
      logic [15:0] shutdown_window;
   } cfg_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       probe_ok;
      logic       resolve_ok;
      logic       reprobe_ok;
      logic [1:0] new_mode;
   } item_type;

   typedef struct packed {
      mode_type   mode;
      event_type  event_res;
      logic       force_shutdown;
      logic [3:0] probe_misses;
      logic [3:0] resolve_misses;
   } result_type;

endpackage

[design/hlw_csr.sv]
module hlw_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output logic             csr_ready,
   output hlw_pkg::cfg_type cfg
);

   hlw_pkg::cfg_type cfg_ff;
   hlw_pkg::cfg_type cfg_in;

   // Always able to take a write
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index and merge the write data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hlw_pkg::CSR_PROBE_MISS_LIMIT:   cfg_in.probe_miss_limit   = csr_wdata[3:0];
            hlw_pkg::CSR_RESOLVE_MISS_LIMIT: cfg_in.resolve_miss_limit = csr_wdata[3:0];
            hlw_pkg::CSR_BOOT_WINDOW:        cfg_in.boot_window        = csr_wdata;
            hlw_pkg::CSR_SHUTDOWN_WINDOW:    cfg_in.shutdown_window    = csr_wdata;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.probe_miss_limit   <= hlw_pkg::PROBE_MISS_LIMIT_RST;
         cfg_ff.resolve_miss_limit <= hlw_pkg::RESOLVE_MISS_LIMIT_RST;
         cfg_ff.boot_window        <= hlw_pkg::BOOT_WINDOW_RST;
         cfg_ff.shutdown_window    <= hlw_pkg::SHUTDOWN_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/hlw_engine.sv]
module hlw_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  hlw_pkg::item_type   item,
   input  hlw_pkg::cfg_type    cfg,
   output hlw_pkg::result_type result
);

   hlw_pkg::mode_type mode_ff, mode_in;
   logic [15:0]       elapsed_ff, elapsed_in;
   logic              known_ff, known_in;
   logic [3:0]        pm_ff, pm_in;
   logic [3:0]        rm_ff, rm_in;

   logic [3:0]         pm_inc;
   logic [3:0]         rm_inc;
   hlw_pkg::event_type ev;
   logic               force_sd;

   assign pm_inc = pm_ff + 4'd1;
   assign rm_inc = rm_ff + 4'd1;

   // Work out the state after the current item
   always_comb begin
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      known_in   = known_ff;
      pm_in      = pm_ff;
      rm_in      = rm_ff;
      ev         = hlw_pkg::EV_NONE;
      force_sd   = 1'b0;
      case (item.opcode)
         hlw_pkg::OP_TICK: begin
            if (elapsed_ff != hlw_pkg::ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
         end
         hlw_pkg::OP_SET_MODE: begin
            if (item.new_mode != hlw_pkg::MODE_SEL_INVALID) begin
               mode_in    = hlw_pkg::mode_type'(item.new_mode);
               elapsed_in = '0;
            end
         end
         hlw_pkg::OP_POLL: begin
            if (!known_ff) begin
               // learn the address on the first successful resolution
               if (item.resolve_ok) begin
                  known_in = 1'b1;
                  ev       = hlw_pkg::EV_LEARNED;
               end
            end else if (mode_ff == hlw_pkg::MODE_BOOTING) begin
               if (elapsed_ff >= cfg.boot_window) begin
                  ev      = hlw_pkg::EV_BOOT_TIMEOUT;
                  mode_in = hlw_pkg::MODE_IDLE;
               end else if (item.resolve_ok && item.reprobe_ok) begin
                  ev      = hlw_pkg::EV_BOOTED;
                  mode_in = hlw_pkg::MODE_IDLE;
               end
               pm_in = '0;
               rm_in = '0;
            end else if (mode_ff == hlw_pkg::MODE_SHUTTING) begin
               if (elapsed_ff >= cfg.shutdown_window || !item.probe_ok) begin
                  ev      = hlw_pkg::EV_SHUT_DOWN;
                  mode_in = hlw_pkg::MODE_IDLE;
               end
               pm_in = '0;
               rm_in = '0;
            end else if (item.probe_ok) begin
               pm_in = '0;
               rm_in = '0;
            end else if (pm_inc < cfg.probe_miss_limit) begin
               pm_in = pm_inc;
               ev    = hlw_pkg::EV_PROBE_MISS;
            end else begin
               // probe limit reached: judge the re-resolution round
               pm_in = '0;
               if (item.resolve_ok && item.reprobe_ok) begin
                  rm_in = '0;
                  ev    = hlw_pkg::EV_REFRESHED;
               end else if (rm_inc < cfg.resolve_miss_limit) begin
                  rm_in = rm_inc;
                  ev    = hlw_pkg::EV_RESOLVE_MISS;
               end else begin
                  rm_in      = '0;
                  ev         = hlw_pkg::EV_FREEZE;
                  force_sd   = 1'b1;
                  mode_in    = hlw_pkg::MODE_BOOTING;
                  elapsed_in = '0;
               end
            end
         end
         default: ev = hlw_pkg::EV_NONE;
      endcase
   end

   assign result.mode           = mode_in;
   assign result.event_res      = ev;
   assign result.force_shutdown = force_sd;
   assign result.probe_misses   = pm_in;
   assign result.resolve_misses = rm_in;

   // Commit the state when the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= hlw_pkg::MODE_IDLE;
         elapsed_ff <= '0;
         known_ff   <= 1'b0;
         pm_ff      <= '0;
         rm_ff      <= '0;
      end else if (step) begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         known_ff   <= known_in;
         pm_ff      <= pm_in;
         rm_ff      <= rm_in;
      end
   end

endmodule

[design/host_liveness_watchdog.sv]
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall  opcode, probe_ok, resolve_ok, reprobe_ok, new_mode
// rsp_      out        rsp_valid/rsp_stall  mode, event_res, force_shutdown, probe/resolve misses
// csr_      in         csr_valid/csr_ready  csr_index (2 bits), csr_wdata (16 bits)
//
// One item per cycle unless rsp_stall holds the flow; a result passes the input register,
// then the result register, and transfers when rsp_stall is low.
// The watchdog state updates as an item moves from the input register to the result register.
// Synchronous active-high reset clears the state and loads the default configuration.
// A stall on rsp_ holds both stages; req_stall rises only while the input register is full
// and the result register cannot drain.
module host_liveness_watchdog (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic        req_probe_ok,
   input  logic        req_resolve_ok,
   input  logic        req_reprobe_ok,
   input  logic [1:0]  req_new_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_mode,
   output logic [3:0]  rsp_event_res,
   output logic        rsp_force_shutdown,
   output logic [3:0]  rsp_probe_misses,
   output logic [3:0]  rsp_resolve_misses,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   hlw_pkg::cfg_type    cfg;
   hlw_pkg::item_type   item_ff, item_in;
   hlw_pkg::result_type result, result_ff;
   logic                in_valid_ff, in_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance;
   logic                load_in;

   hlw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   hlw_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (in_valid_ff && advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Advance when the result register is empty or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign load_in   = req_valid && !req_stall;

   assign item_in.opcode     = req_opcode;
   assign item_in.probe_ok   = req_probe_ok;
   assign item_in.resolve_ok = req_resolve_ok;
   assign item_in.reprobe_ok = req_reprobe_ok;
   assign item_in.new_mode   = req_new_mode;

   assign in_valid_in  = load_in || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? in_valid_ff : 1'b1;

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (load_in) begin
         item_ff <= item_in;
      end
      if (advance && in_valid_ff) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = result_ff.mode;
   assign rsp_event_res      = result_ff.event_res;
   assign rsp_force_shutdown = result_ff.force_shutdown;
   assign rsp_probe_misses   = result_ff.probe_misses;
   assign rsp_resolve_misses = result_ff.resolve_misses;

   // Force-shutdown pulses only with a freeze
   a_force_freeze : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_force_shutdown == (rsp_event_res == hlw_pkg::EV_FREEZE)))
      else $error("force_shutdown out of step with freeze event");

   // A freeze leaves the host booting with clear counters
   a_freeze_state : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_force_shutdown) |->
         (rsp_mode == hlw_pkg::MODE_BOOTING && rsp_probe_misses == 4'd0
          && rsp_resolve_misses == 4'd0))
      else $error("freeze result with wrong mode or counters");

   // Escalation events only arise in idle mode
   a_idle_events : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == hlw_pkg::EV_PROBE_MISS
                     || rsp_event_res == hlw_pkg::EV_REFRESHED
                     || rsp_event_res == hlw_pkg::EV_RESOLVE_MISS))
         |-> (rsp_mode == hlw_pkg::MODE_IDLE))
      else $error("escalation event outside idle mode");

   // Stall the input only with an item waiting
   a_stall_held : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled with nothing buffered");

endmodule
